### sv/gvc_pkg.sv
// shared types and constants of the grid visit count table
// no dependencies; every file that uses this package refers to it by scoped names

package gvc_pkg;

	// stream payload widths
	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned IN_TUSER_W  = 2;
	localparam int unsigned OUT_TDATA_W = 40;
	localparam int unsigned OUT_TUSER_W = 5;

	// configuration channel
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;

	// field widths
	localparam int unsigned AGENT_W = 4;
	localparam int unsigned POS_W   = 6;
	localparam int unsigned CNT_W   = 8;
	localparam int unsigned EPOCH_W = 8;
	localparam int unsigned ENTRY_W = EPOCH_W + CNT_W;

	localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_PLACE = 2'd1,
		MODE_VISIT = 2'd2,
		MODE_PEEK  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AGENT_COUNT = 3'd0,
		CFG_GRID_WIDTH  = 3'd1,
		CFG_GRID_HEIGHT = 3'd2,
		CFG_VIEW_HEIGHT = 3'd3,
		CFG_VIEW_WIDTH  = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_RD_C,
		ST_RD_N,
		ST_RD_S,
		ST_RD_E,
		ST_RD_W,
		ST_FIN
	} state_t;

	// which cell a memory read is aimed at
	typedef enum logic [2:0] {
		PH_NONE,
		PH_C,
		PH_N,
		PH_S,
		PH_E,
		PH_W
	} phase_t;

	typedef struct packed {
		logic   accept;
		logic   sweep;
		logic   load;
		phase_t phase;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic sweep_pend;
		logic out_busy;
	} stat_t;

endpackage

### sv/grid_visit_count_table.sv
// grid visit count table: one 8-bit saturating count per agent and grid cell, held in a single
// memory of MAX_AGENTS * MAX_SIDE * MAX_SIDE entries. each item names a mode (clear, place,
// visit, or read-only peek), an agent and a cell, and returns one result item: the centre count
// after the update, the four neighbour counts (zero off the grid), four window-shown flags and an
// error flag for an agent or cell outside the configured range (counts then zero, no update).
// after acceptance an item goes through five reads (centre, north, south, east, west) that go
// one a cycle through the single read port of the store, then a state that loads the result;
// the centre write-back shares the read cycles. items are handled one at a time, and the next
// one is taken at the earliest in the cycle after the load. a new item is taken while the
// previous result waits in the output register; a result still waiting when the next one is
// ready holds the load back. after reset the block sweeps all MAX_AGENTS * MAX_SIDE * MAX_SIDE
// entries of the store (65536 at the defaults) to zero, one entry a cycle, before tready rises.
// a clear is an epoch bump and needs no sweep of its own, except that every 256th clear is
// followed by the same sweep once its result is loaded.
// depends on gvc_pkg, gvc_ctrl, gvc_dp

module grid_visit_count_table #(
	parameter int unsigned MAX_AGENTS = 16,
	parameter int unsigned MAX_SIDE   = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel, always ready
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gvc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gvc_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input items
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [gvc_pkg::IN_TDATA_W-1:0]     s_tdata,  // agent[3:0], row[9:4], column[15:10]
	input  logic [gvc_pkg::IN_TUSER_W-1:0]     s_tuser,  // mode[1:0]
	// result items
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// center_count, north_count, south_count, east_count, west_count, 8 bits each from bit 0
	output logic [gvc_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// north_shown[0], south_shown[1], east_shown[2], west_shown[3], error[4]
	output logic [gvc_pkg::OUT_TUSER_W-1:0]    m_tuser
);

	gvc_pkg::cmd_t  cmd;
	gvc_pkg::stat_t stat;

	// registers are plain flops, so a write is taken every cycle
	assign cfg_ready = 1'b1;

	gvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	gvc_dp #(
		.MAX_AGENTS (MAX_AGENTS),
		.MAX_SIDE   (MAX_SIDE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

### sv/gvc_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies

module gvc_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### sv/gvc_ctrl.sv
// sequencer of the grid visit count table: clearing sweep, five reads, result load
// depends on gvc_pkg

module gvc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  gvc_pkg::stat_t stat,
	output logic          s_tready,
	output gvc_pkg::cmd_t cmd
);

	gvc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gvc_pkg::ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gvc_pkg::ST_SWEEP: begin
				if (stat.sweep_last) state_d = gvc_pkg::ST_IDLE;
			end
			gvc_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = gvc_pkg::ST_RD_C;
			end
			gvc_pkg::ST_RD_C: state_d = gvc_pkg::ST_RD_N;
			gvc_pkg::ST_RD_N: state_d = gvc_pkg::ST_RD_S;
			gvc_pkg::ST_RD_S: state_d = gvc_pkg::ST_RD_E;
			gvc_pkg::ST_RD_E: state_d = gvc_pkg::ST_RD_W;
			gvc_pkg::ST_RD_W: state_d = gvc_pkg::ST_FIN;
			gvc_pkg::ST_FIN: begin
				if (!stat.out_busy) begin
					state_d = stat.sweep_pend ? gvc_pkg::ST_SWEEP : gvc_pkg::ST_IDLE;
				end
			end
			default: state_d = gvc_pkg::ST_SWEEP;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.sweep  = 1'b0;
		cmd.load   = 1'b0;
		cmd.phase  = gvc_pkg::PH_NONE;
		case (state_q)
			gvc_pkg::ST_SWEEP: cmd.sweep = 1'b1;
			gvc_pkg::ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			gvc_pkg::ST_RD_C: cmd.phase = gvc_pkg::PH_C;
			gvc_pkg::ST_RD_N: cmd.phase = gvc_pkg::PH_N;
			gvc_pkg::ST_RD_S: cmd.phase = gvc_pkg::PH_S;
			gvc_pkg::ST_RD_E: cmd.phase = gvc_pkg::PH_E;
			gvc_pkg::ST_RD_W: cmd.phase = gvc_pkg::PH_W;
			gvc_pkg::ST_FIN:  cmd.load  = !stat.out_busy;
			default: cmd.sweep = 1'b0;
		endcase
	end

endmodule

### sv/gvc_dp.sv
// datapath of the grid visit count table: registers, address, epoch-tagged store, result
// depends on gvc_pkg and gvc_ram

module gvc_dp #(
	parameter int unsigned MAX_AGENTS = 16,
	parameter int unsigned MAX_SIDE   = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gvc_pkg::cmd_t                      cmd,
	output gvc_pkg::stat_t                     stat,
	input  logic                               cfg_valid,
	input  logic [gvc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gvc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [gvc_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic [gvc_pkg::IN_TUSER_W-1:0]     s_tuser,
	input  logic                               m_tready,
	output logic                               m_tvalid,
	output logic [gvc_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic [gvc_pkg::OUT_TUSER_W-1:0]    m_tuser
);

	localparam int unsigned DEPTH   = MAX_AGENTS * MAX_SIDE * MAX_SIDE;
	localparam int unsigned SIDE_SQ = MAX_SIDE * MAX_SIDE;
	localparam int unsigned AW      = $clog2(DEPTH);

	localparam int unsigned CW = gvc_pkg::CNT_W;
	localparam int unsigned EW = gvc_pkg::EPOCH_W;

	// configuration registers
	logic [4:0] agent_count_q;
	logic [6:0] grid_width_q;
	logic [6:0] grid_height_q;
	logic [7:0] view_height_q;
	logic [7:0] view_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agent_count_q <= 5'd1;
			grid_width_q  <= 7'd64;
			grid_height_q <= 7'd64;
			view_height_q <= 8'd11;
			view_width_q  <= 8'd11;
		end else if (cfg_valid) begin
			case (gvc_pkg::cfg_idx_t'(cfg_index))
				gvc_pkg::CFG_AGENT_COUNT: agent_count_q <= cfg_data[4:0];
				gvc_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_data[6:0];
				gvc_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data[6:0];
				gvc_pkg::CFG_VIEW_HEIGHT: view_height_q <= cfg_data;
				gvc_pkg::CFG_VIEW_WIDTH:  view_width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input decode and range check
	logic [gvc_pkg::AGENT_W-1:0] agent_in;
	logic [gvc_pkg::POS_W-1:0]   row_in, col_in;
	gvc_pkg::mode_t              mode_in;
	logic [8:0]                  agent9, row9, col9;
	logic                        bad_in;
	logic [AW-1:0]               addr_in;

	assign agent_in = s_tdata[3:0];
	assign row_in   = s_tdata[9:4];
	assign col_in   = s_tdata[15:10];
	assign mode_in  = gvc_pkg::mode_t'(s_tuser);
	assign agent9   = 9'(agent_in);
	assign row9     = 9'(row_in);
	assign col9     = 9'(col_in);

	assign bad_in = (agent9 >= 9'(agent_count_q)) || (agent9 >= 9'(MAX_AGENTS))
		|| (row9 >= 9'(grid_height_q)) || (row9 >= 9'(MAX_SIDE))
		|| (col9 >= 9'(grid_width_q)) || (col9 >= 9'(MAX_SIDE));

	assign addr_in = AW'(agent_in) * AW'(SIDE_SQ) + AW'(row_in) * AW'(MAX_SIDE) + AW'(col_in);

	// item registers
	gvc_pkg::mode_t mode_q;
	logic [AW-1:0]  addr_q;
	logic           bad_q, ok_q, nv_q, sv_q, ev_q, wv_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= mode_in;
			addr_q <= addr_in;
			bad_q  <= bad_in;
			ok_q   <= !bad_in && (mode_in != gvc_pkg::MODE_CLEAR);
			nv_q   <= row_in != '0;
			sv_q   <= ((row9 + 9'd1) < 9'(grid_height_q)) && ((row9 + 9'd1) < 9'(MAX_SIDE));
			ev_q   <= ((col9 + 9'd1) < 9'(grid_width_q)) && ((col9 + 9'd1) < 9'(MAX_SIDE));
			wv_q   <= col_in != '0;
		end
	end

	// epoch and clearing sweep
	logic [EW-1:0] epoch_q;
	logic          sweep_pend_q;
	logic [AW-1:0] sweep_cnt_q;

	assign stat.sweep_last = sweep_cnt_q == AW'(DEPTH - 1);
	assign stat.sweep_pend = sweep_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q      <= '0;
			sweep_pend_q <= 1'b0;
			sweep_cnt_q  <= '0;
		end else begin
			if (cmd.accept && mode_in == gvc_pkg::MODE_CLEAR) begin
				epoch_q <= epoch_q + EW'(1);
				if (epoch_q == '1) sweep_pend_q <= 1'b1;
			end
			if (cmd.sweep) begin
				sweep_cnt_q <= stat.sweep_last ? '0 : sweep_cnt_q + AW'(1);
				if (stat.sweep_last) sweep_pend_q <= 1'b0;
			end
		end
	end

	// memory access
	logic                        rd_en, wr_en;
	logic [AW-1:0]               rd_addr, wr_addr;
	logic [gvc_pkg::ENTRY_W-1:0] rd_data, wr_data;
	logic                        rd_mask;
	gvc_pkg::phase_t             ph_s1;
	logic [CW-1:0]               cnt_rd, cnt_new;

	always_comb begin
		rd_addr = addr_q;
		rd_mask = 1'b0;
		case (cmd.phase)
			gvc_pkg::PH_C: rd_mask = 1'b1;
			gvc_pkg::PH_N: begin
				rd_addr = addr_q - AW'(MAX_SIDE);
				rd_mask = nv_q;
			end
			gvc_pkg::PH_S: begin
				rd_addr = addr_q + AW'(MAX_SIDE);
				rd_mask = sv_q;
			end
			gvc_pkg::PH_E: begin
				rd_addr = addr_q + AW'(1);
				rd_mask = ev_q;
			end
			gvc_pkg::PH_W: begin
				rd_addr = addr_q - AW'(1);
				rd_mask = wv_q;
			end
			default: rd_mask = 1'b0;
		endcase
	end

	assign rd_en = ok_q && rd_mask;

	// an entry written under an older epoch reads as zero
	assign cnt_rd = (rd_data[gvc_pkg::ENTRY_W-1:CW] == epoch_q) ? rd_data[CW-1:0] : '0;

	always_comb begin
		case (mode_q)
			gvc_pkg::MODE_PLACE: cnt_new = CW'(1);
			gvc_pkg::MODE_VISIT: cnt_new = (cnt_rd == gvc_pkg::COUNT_MAX) ? cnt_rd
				: cnt_rd + CW'(1);
			default: cnt_new = cnt_rd;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = {epoch_q, cnt_new};
		if (cmd.sweep) begin
			wr_en   = 1'b1;
			wr_addr = sweep_cnt_q;
			wr_data = '0;
		end else if (ph_s1 == gvc_pkg::PH_C) begin
			wr_en = ok_q && (mode_q == gvc_pkg::MODE_PLACE || mode_q == gvc_pkg::MODE_VISIT);
		end
	end

	gvc_ram #(
		.WIDTH (gvc_pkg::ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_s1 <= gvc_pkg::PH_NONE;
		end else begin
			ph_s1 <= cmd.phase;
		end
	end

	// capture of returned counts
	logic [CW-1:0] ctr_q, n_q, s_q, e_q;

	always_ff @(posedge clk) begin
		case (ph_s1)
			gvc_pkg::PH_C: ctr_q <= ok_q ? cnt_new : '0;
			gvc_pkg::PH_N: n_q   <= (ok_q && nv_q) ? cnt_rd : '0;
			gvc_pkg::PH_S: s_q   <= (ok_q && sv_q) ? cnt_rd : '0;
			gvc_pkg::PH_E: e_q   <= (ok_q && ev_q) ? cnt_rd : '0;
			default: ;
		endcase
	end

	// output register
	logic [6:0] vr, vc;
	logic       north_sh, south_sh, east_sh, west_sh;
	logic [CW-1:0] w_cnt;

	assign vr       = view_height_q[7:1];
	assign vc       = view_width_q[7:1];
	assign north_sh = vr != '0;
	assign west_sh  = vc != '0;
	assign south_sh = (8'(vr) + 8'd1) < view_height_q;
	assign east_sh  = (8'(vc) + 8'd1) < view_width_q;
	assign w_cnt    = (ok_q && wv_q) ? cnt_rd : '0;

	logic m_tvalid_q;
	logic [gvc_pkg::OUT_TDATA_W-1:0] m_tdata_q;
	logic [gvc_pkg::OUT_TUSER_W-1:0] m_tuser_q;

	assign stat.out_busy = m_tvalid_q && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_tdata_q <= {w_cnt, e_q, s_q, n_q, ctr_q};
			m_tuser_q <= {bad_q, west_sh, east_sh, south_sh, north_sh};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

### sv/gvc_checker.sv
// port-level checks of the grid visit count table, attached by bind
// depends on gvc_pkg and grid_visit_count_table

module gvc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [gvc_pkg::IN_TDATA_W-1:0]  s_tdata,
	input logic [gvc_pkg::IN_TUSER_W-1:0]  s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [gvc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [gvc_pkg::OUT_TUSER_W-1:0] m_tuser
);

	// one item in flight: no second item right after an acceptance
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while another is in flight");

	// a fresh result follows its item after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 7))
		else $error("result without matching item");

	// an out-of-range item carries no counts
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[4] |-> m_tdata == '0)
		else $error("error result with nonzero counts");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind grid_visit_count_table gvc_checker u_gvc_checker (.*);

### tb/gvc_result_checker.sv
// result checker for the grid visit count table: follows the configuration writes and the
// input items, predicts each result item and compares it with what the block returns
// depends on gvc_pkg
`timescale 1ns / 100ps

module gvc_result_checker #(
	parameter int unsigned MAX_AGENTS = 16,
	parameter int unsigned MAX_SIDE   = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [gvc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gvc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic [gvc_pkg::IN_TDATA_W-1:0]     s_tdata,  // agent[3:0], row[9:4], column[15:10]
	input  logic [gvc_pkg::IN_TUSER_W-1:0]     s_tuser,  // mode[1:0]
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [gvc_pkg::OUT_TDATA_W-1:0]    m_tdata,  // centre, north, south, east, west
	input  logic [gvc_pkg::OUT_TUSER_W-1:0]    m_tuser,  // n, s, e, w shown, error
	output int unsigned                        mismatches,
	output int unsigned                        outstanding
);

	typedef struct packed {
		logic [7:0] centre;
		logic [7:0] north;
		logic [7:0] south;
		logic [7:0] east;
		logic [7:0] west;
		logic       north_shown;
		logic       south_shown;
		logic       east_shown;
		logic       west_shown;
		logic       err;
	} neighbourhood_t;

	// shadow of the configuration registers
	logic [4:0] agent_count_q;
	logic [6:0] grid_width_q;
	logic [6:0] grid_height_q;
	logic [7:0] view_height_q;
	logic [7:0] view_width_q;

	// sparse copy of the count store, a missing key reads as zero
	logic [7:0] visit_count [int unsigned];
	neighbourhood_t expected_views [$];
	int unsigned fails;

	function automatic int unsigned cell_key(int unsigned a, int unsigned r, int unsigned c);
		return (a * MAX_SIDE + r) * MAX_SIDE + c;
	endfunction

	function automatic logic [7:0] count_at(int unsigned a, int unsigned r, int unsigned c);
		int unsigned key;
		key = cell_key(a, r, c);
		return visit_count.exists(key) ? visit_count[key] : 8'd0;
	endfunction

	// applies one item to the store copy and returns the view it should produce
	function automatic neighbourhood_t visit_and_observe(gvc_pkg::mode_t mode, int unsigned a,
			int unsigned r, int unsigned c);
		int unsigned agents, rows, cols, half_h, half_w;
		logic [7:0] cur;
		neighbourhood_t v;
		agents = (agent_count_q < MAX_AGENTS) ? agent_count_q : MAX_AGENTS;
		rows   = (grid_height_q < MAX_SIDE) ? grid_height_q : MAX_SIDE;
		cols   = (grid_width_q < MAX_SIDE) ? grid_width_q : MAX_SIDE;
		half_h = view_height_q / 2;
		half_w = view_width_q / 2;
		v = '0;
		v.err         = (a >= agents) || (r >= rows) || (c >= cols);
		v.north_shown = half_h > 0;
		v.south_shown = half_h + 1 < view_height_q;
		v.east_shown  = half_w + 1 < view_width_q;
		v.west_shown  = half_w > 0;
		if (mode == gvc_pkg::MODE_CLEAR)
			visit_count.delete();
		if (!v.err) begin
			cur = count_at(a, r, c);
			if (mode == gvc_pkg::MODE_PLACE)
				visit_count[cell_key(a, r, c)] = 8'd1;
			else if (mode == gvc_pkg::MODE_VISIT && cur < gvc_pkg::COUNT_MAX)
				visit_count[cell_key(a, r, c)] = cur + 8'd1;
			v.centre = count_at(a, r, c);
			if (r > 0)
				v.north = count_at(a, r - 1, c);
			if (r + 1 < rows)
				v.south = count_at(a, r + 1, c);
			if (c + 1 < cols)
				v.east = count_at(a, r, c + 1);
			if (c > 0)
				v.west = count_at(a, r, c - 1);
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		neighbourhood_t got, want, next_view;
		if (!arst_n) begin
			agent_count_q <= 5'd1;
			grid_width_q  <= 7'd64;
			grid_height_q <= 7'd64;
			view_height_q <= 8'd11;
			view_width_q  <= 8'd11;
			visit_count.delete();
			expected_views.delete();
			fails = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// result side first: a result never belongs to an item taken at the same edge
			if (m_tvalid && m_tready) begin
				got.centre      = m_tdata[7:0];
				got.north       = m_tdata[15:8];
				got.south       = m_tdata[23:16];
				got.east        = m_tdata[31:24];
				got.west        = m_tdata[39:32];
				got.north_shown = m_tuser[0];
				got.south_shown = m_tuser[1];
				got.east_shown  = m_tuser[2];
				got.west_shown  = m_tuser[3];
				got.err         = m_tuser[4];
				if (expected_views.size() == 0) begin
					if (fails < 10)
						$display("%0t: result item with nothing outstanding", $realtime);
					fails++;
				end else begin
					want = expected_views.pop_front();
					if (got !== want) begin
						if (fails < 10) begin
							$display("%0t: result mismatch", $realtime);
							$display("  expected c=%0d n=%0d s=%0d e=%0d w=%0d nsew shown=%b%b%b%b err=%b",
								want.centre, want.north, want.south, want.east, want.west,
								want.north_shown, want.south_shown, want.east_shown,
								want.west_shown, want.err);
							$display("  actual   c=%0d n=%0d s=%0d e=%0d w=%0d nsew shown=%b%b%b%b err=%b",
								got.centre, got.north, got.south, got.east, got.west,
								got.north_shown, got.south_shown, got.east_shown,
								got.west_shown, got.err);
						end
						fails++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				next_view = visit_and_observe(gvc_pkg::mode_t'(s_tuser),
					s_tdata[3:0], s_tdata[9:4], s_tdata[15:10]);
				expected_views.insert(expected_views.size(), next_view);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gvc_pkg::CFG_AGENT_COUNT: agent_count_q <= cfg_data[4:0];
					gvc_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_data[6:0];
					gvc_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data[6:0];
					gvc_pkg::CFG_VIEW_HEIGHT: view_height_q <= cfg_data;
					gvc_pkg::CFG_VIEW_WIDTH:  view_width_q  <= cfg_data;
					default: ;
				endcase
			end
			mismatches  <= fails;
			outstanding <= expected_views.size();
		end
	end

endmodule

### tb/tb.sv
// top of the grid visit count table testbench: clock, reset, configuration phases and
// input items, random stalls on the result side, and the final verdict
// depends on gvc_pkg, grid_visit_count_table and gvc_result_checker
`timescale 1ns / 100ps

module tb;

	localparam int unsigned MAX_AGENTS = 16;
	localparam int unsigned MAX_SIDE   = 64;

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [gvc_pkg::CFG_IDX_W-1:0]       cfg_index = gvc_pkg::CFG_AGENT_COUNT;
	logic [gvc_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;
	logic                                s_tvalid  = 1'b0;
	logic                                s_tready;
	// agent[3:0], row[9:4], column[15:10]
	logic [gvc_pkg::IN_TDATA_W-1:0]      s_tdata   = '0;
	logic [gvc_pkg::IN_TUSER_W-1:0]      s_tuser   = gvc_pkg::MODE_PEEK;  // mode[1:0]
	logic                                m_tvalid;
	logic                                m_tready  = 1'b0;
	// centre, north, south, east, west counts from bit 0
	logic [gvc_pkg::OUT_TDATA_W-1:0]     m_tdata;
	// north, south, east, west shown, error from bit 0
	logic [gvc_pkg::OUT_TUSER_W-1:0]     m_tuser;

	int unsigned mismatches;
	int unsigned outstanding;

	// quiet stretches: no gaps on the input side and no stalls on the result side
	bit          quiet = 1'b0;
	int unsigned stall_left = 0;

	always #2 clk = ~clk;

	grid_visit_count_table #(
		.MAX_AGENTS (MAX_AGENTS),
		.MAX_SIDE   (MAX_SIDE)
	) i_dut (.*);

	gvc_result_checker #(
		.MAX_AGENTS (MAX_AGENTS),
		.MAX_SIDE   (MAX_SIDE)
	) i_checker (.*);

	// mostly short idle stretches, now and then a long one
	function automatic int unsigned idle_cycles();
		int unsigned roll;
		if (quiet)
			return 0;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		else if (roll < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// result side back-pressure, restarted from the same distribution after each stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if (!quiet && $urandom_range(99) < 20)
				stall_left <= idle_cycles() + 1;
		end
	end

	// one input item; returns at the edge where it is taken, tvalid still high
	task automatic send_item(gvc_pkg::mode_t mode, logic [3:0] agent, logic [5:0] row,
			logic [5:0] col);
		int unsigned gap;
		gap = idle_cycles();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {col, row, agent};
		do @(posedge clk); while (!s_tready);
	endtask

	// waits until every outstanding result is back, then lets the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// writes all five registers back to back while the block is idle
	task automatic load_config(int unsigned agents, int unsigned width, int unsigned height,
			int unsigned view_h, int unsigned view_w);
		logic [7:0] vals [5];
		vals = '{8'(agents), 8'(width), 8'(height), 8'(view_h), 8'(view_w)};
		drain();
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= gvc_pkg::cfg_idx_t'(3'(i));
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// random items inside a box of agents and cells, with a share of fully random noise
	task automatic random_items(int unsigned n, int unsigned pct_clear, int unsigned pct_place,
			int unsigned pct_peek, int unsigned pct_noise, int unsigned agent_hi,
			int unsigned row_lo, int unsigned row_hi, int unsigned col_lo, int unsigned col_hi);
		gvc_pkg::mode_t mode;
		int unsigned    roll;
		logic [3:0]     agent;
		logic [5:0]     row, col;
		repeat (n) begin
			roll = $urandom_range(99);
			if (roll < pct_clear)
				mode = gvc_pkg::MODE_CLEAR;
			else if (roll < pct_clear + pct_place)
				mode = gvc_pkg::MODE_PLACE;
			else if (roll < pct_clear + pct_place + pct_peek)
				mode = gvc_pkg::MODE_PEEK;
			else
				mode = gvc_pkg::MODE_VISIT;
			if ($urandom_range(99) < pct_noise) begin
				agent = 4'($urandom);
				row   = 6'($urandom);
				col   = 6'($urandom);
			end else begin
				agent = 4'($urandom_range(agent_hi));
				row   = 6'($urandom_range(row_hi, row_lo));
				col   = 6'($urandom_range(col_hi, col_lo));
			end
			send_item(mode, agent, row, col);
		end
	endtask

	// run limit, well above the slowest correct run including the two store sweeps
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed items at reset settings: one agent, full 64 x 64 grid, 11 x 11 window
		send_item(gvc_pkg::MODE_PEEK,  4'd0,  6'd0,  6'd0);   // untouched store reads zero
		send_item(gvc_pkg::MODE_PLACE, 4'd0,  6'd0,  6'd0);   // corner, north and west off grid
		send_item(gvc_pkg::MODE_VISIT, 4'd0,  6'd0,  6'd1);
		send_item(gvc_pkg::MODE_VISIT, 4'd0,  6'd1,  6'd0);
		send_item(gvc_pkg::MODE_VISIT, 4'd0,  6'd63, 6'd63);  // far corner, south and east off
		send_item(gvc_pkg::MODE_VISIT, 4'd0,  6'd62, 6'd63);
		send_item(gvc_pkg::MODE_VISIT, 4'd0,  6'd63, 6'd62);
		send_item(gvc_pkg::MODE_VISIT, 4'd0,  6'd63, 6'd63);
		send_item(gvc_pkg::MODE_PLACE, 4'd0,  6'd63, 6'd63);  // place pulls a count back to one
		send_item(gvc_pkg::MODE_VISIT, 4'd1,  6'd5,  6'd5);   // agent beyond the count in use
		send_item(gvc_pkg::MODE_VISIT, 4'd15, 6'd63, 6'd63);
		send_item(gvc_pkg::MODE_PEEK,  4'd0,  6'd0,  6'd1);
		send_item(gvc_pkg::MODE_CLEAR, 4'd15, 6'd0,  6'd0);   // clear still flags the bad agent
		send_item(gvc_pkg::MODE_PEEK,  4'd0,  6'd0,  6'd0);
		send_item(gvc_pkg::MODE_VISIT, 4'd0,  6'd31, 6'd32);
		send_item(gvc_pkg::MODE_VISIT, 4'd0,  6'd32, 6'd31);
		send_item(gvc_pkg::MODE_CLEAR, 4'd0,  6'd0,  6'd0);
		send_item(gvc_pkg::MODE_VISIT, 4'd0,  6'd21, 6'd42);
		send_item(gvc_pkg::MODE_PEEK,  4'd0,  6'd32, 6'd31);

		// configured grid edge below the memory edge
		load_config(16, 5, 3, 2, 3);
		send_item(gvc_pkg::MODE_VISIT, 4'd15, 6'd2, 6'd4);
		send_item(gvc_pkg::MODE_VISIT, 4'd15, 6'd1, 6'd4);
		send_item(gvc_pkg::MODE_VISIT, 4'd15, 6'd2, 6'd5);    // column just outside
		send_item(gvc_pkg::MODE_VISIT, 4'd15, 6'd3, 6'd0);    // row just outside

		// all agents, full grid, smallest window; activity kept near one corner
		load_config(16, 64, 64, 1, 1);
		quiet <= 1'b1;
		random_items(30, 2, 10, 10, 20, 3, 60, 63, 0, 3);
		quiet <= 1'b0;

		// tiny grid with frequent out-of-range cells
		load_config(2, 5, 3, 2, 3);
		random_items(30, 3, 10, 10, 10, 2, 0, 3, 0, 5);

		// single cell hammered until the count holds at its ceiling
		load_config(1, 1, 1, 255, 255);
		quiet <= 1'b1;
		random_items(100, 0, 0, 2, 0, 0, 0, 0, 0, 0);
		quiet <= 1'b0;
		random_items(170, 0, 0, 2, 0, 0, 0, 0, 0, 0);

		// no agent in use: every item reports an error
		load_config(0, 64, 64, 254, 128);
		random_items(10, 10, 20, 10, 100, 15, 0, 63, 0, 63);

		// fill a small patch, run a long burst of clears across the epoch wrap, then revisit
		load_config(16, 64, 64, 11, 11);
		random_items(15, 0, 5, 5, 0, 1, 0, 2, 0, 2);
		random_items(258, 100, 0, 0, 100, 15, 0, 63, 0, 63);
		random_items(15, 0, 5, 10, 0, 1, 0, 2, 0, 2);

		drain();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
sv/gvc_pkg.sv
sv/gvc_ram.sv
sv/gvc_ctrl.sv
sv/gvc_dp.sv
sv/grid_visit_count_table.sv
sv/gvc_checker.sv
tb/gvc_result_checker.sv
tb/tb.sv
